### rtl/core/pra_pkg.sv
// Shared types, widths and codes of the page range allocator.
package pra_pkg;

   localparam int PRA_FREE_LIST_DEPTH = 128;
   localparam int PRA_PAGE_BYTES      = 4096;

   localparam int ADDR_W   = 64;
   localparam int SIZE_W   = 49;
   localparam int BASE_W   = 52;
   localparam int LEN_W    = 36;
   localparam int FREE_W   = 8;
   localparam int DROP_W   = 32;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [SIZE_W-1:0] ARENA_SIZE_RESET = SIZE_W'(64'd35184372088832);

   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_SIZE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK             = 3'd0,
      STS_ZERO           = 3'd1,
      STS_OVER_CAP       = 3'd2,
      STS_NO_SPACE       = 3'd3,
      STS_OUTSIDE        = 3'd4,
      STS_MISALIGNED     = 3'd5,
      STS_BACKING_FAILED = 3'd6
   } status_type;

   localparam logic CMD_ALLOCATE = 1'b0;
   localparam logic CMD_RELEASE  = 1'b1;

   typedef enum logic [3:0] {
      PRA_IDLE,
      PRA_DECODE,
      PRA_TAKE_SCAN,
      PRA_BUMP_USED,
      PRA_BUMP_FIT,
      PRA_TAKE_DONE,
      PRA_INS_SCAN,
      PRA_INS_DECIDE,
      PRA_INS_MERGE,
      PRA_INS_PUT,
      PRA_MOVE,
      PRA_DONE
   } pra_state_type;

   typedef struct packed {
      logic              command;
      logic [LEN_W-1:0]  num_pages;
      logic [ADDR_W-1:0] address;
      logic              backing_failed;
   } pra_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   range_address;
      logic [LEN_W-1:0]    pages_in_use;
      logic [LEN_W-1:0]    high_water_mark;
      logic [FREE_W-1:0]   free_range_count;
      logic [DROP_W-1:0]   forfeited_ranges;
   } pra_result_type;

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic [LEN_W-1:0]  len;
   } pra_entry_type;

endpackage

### rtl/core/pra_if.sv
// Request and response channel interfaces of the page range allocator.
interface pra_req_if import pra_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [LEN_W-1:0]  num_pages;
   logic [ADDR_W-1:0] address;
   logic              backing_failed;

   modport source (output valid, command, num_pages, address, backing_failed, input ready);
   modport sink (input valid, command, num_pages, address, backing_failed, output ready);
endinterface

interface pra_rsp_if import pra_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   range_address;
   logic [LEN_W-1:0]    pages_in_use;
   logic [LEN_W-1:0]    high_water_mark;
   logic [FREE_W-1:0]   free_range_count;
   logic [DROP_W-1:0]   forfeited_ranges;

   modport source (output valid, status, range_address, pages_in_use, high_water_mark,
                   free_range_count, forfeited_ranges, input ready);
   modport sink (input valid, status, range_address, pages_in_use, high_water_mark,
                 free_range_count, forfeited_ranges, output ready);
endinterface

### rtl/core/pra_engine.sv
// Free list memory, bump pointer and the sequencer that serves one word at a time.
module pra_engine import pra_pkg::*; #(
   parameter int FREE_LIST_DEPTH = PRA_FREE_LIST_DEPTH,
   parameter int PAGE_BYTES      = PRA_PAGE_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pra_cmd_type       cmd,
   input  logic              out_free,
   input  logic [ADDR_W-1:0] arena_base,
   input  logic [SIZE_W-1:0] arena_size,
   input  logic              bump_load,
   input  logic [ADDR_W-1:0] bump_value,
   output logic              idle,
   output logic              done,
   output pra_result_type    result
);

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int AW         = $clog2(FREE_LIST_DEPTH);
   localparam int CNT_W      = $clog2(FREE_LIST_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FREE_LIST_DEPTH);

   pra_entry_type mem [FREE_LIST_DEPTH];
   pra_entry_type rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   pra_entry_type wr_data;

   pra_state_type     state_ff, state_in;
   pra_cmd_type       cmd_ff, cmd_in;
   logic [BASE_W-1:0] page_ff, page_in;
   status_type        status_ff, status_in;
   logic [ADDR_W-1:0] raddr_ff, raddr_in;
   logic [ADDR_W-1:0] bump_ff, bump_in;
   logic [ADDR_W-1:0] used_ff, used_in;
   logic [LEN_W-1:0]  in_use_ff, in_use_in;
   logic [LEN_W-1:0]  peak_ff, peak_in;
   logic [DROP_W-1:0] drop_ff, drop_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              scan_vld_ff, scan_vld_in;
   pra_entry_type     prev_ff, prev_in;
   pra_entry_type     next_ff, next_in;
   logic              has_prev_ff, has_prev_in;
   logic              has_next_ff, has_next_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  mv_src_ff, mv_src_in;
   logic [CNT_W-1:0]  mv_dst_ff, mv_dst_in;
   logic [CNT_W-1:0]  mv_left_ff, mv_left_in;
   logic              mv_up_ff, mv_up_in;
   logic              mv_pend_ff, mv_pend_in;
   pra_state_type     mv_ret_ff, mv_ret_in;

   logic [SIZE_W-1:0]  cap;
   logic               count_over_cap;
   logic [ADDR_W-1:0]  size64;
   logic [ADDR_W-1:0]  bytes;
   logic [ADDR_W-1:0]  rel_offset;
   logic [CNT_W-1:0]   scan_nxt;
   logic [LEN_W:0]     use_sum;
   logic [LEN_W:0]     prev_len_sum;
   logic [BASE_W:0]    prev_end;
   logic [BASE_W:0]    page_end;
   logic [LEN_W:0]     next_len_sum;
   logic [LEN_W:0]     join_len_sum;
   logic [CNT_W+FREE_W-1:0] free_wide;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign cap            = arena_size >> PAGE_SHIFT;
   assign count_over_cap = SIZE_W'(cmd_ff.num_pages) > cap;
   assign size64         = ADDR_W'(arena_size);
   assign bytes          = ADDR_W'(cmd_ff.num_pages) << PAGE_SHIFT;
   assign rel_offset     = cmd_ff.address - arena_base;
   assign scan_nxt       = scan_idx_ff + 1'b1;
   assign use_sum        = {1'b0, in_use_ff} + {1'b0, cmd_ff.num_pages};
   assign prev_len_sum   = {1'b0, prev_ff.len} + {1'b0, cmd_ff.num_pages};
   assign prev_end       = {1'b0, prev_ff.base} + (BASE_W + 1)'(prev_ff.len);
   assign page_end       = {1'b0, page_ff} + (BASE_W + 1)'(cmd_ff.num_pages);
   assign next_len_sum   = {1'b0, next_ff.len} + {1'b0, cmd_ff.num_pages};
   assign join_len_sum   = {1'b0, prev_ff.len} + {1'b0, next_ff.len};
   assign free_wide      = {{FREE_W{1'b0}}, n_ff};

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      page_in     = page_ff;
      status_in   = status_ff;
      raddr_in    = raddr_ff;
      bump_in     = bump_ff;
      used_in     = used_ff;
      in_use_in   = in_use_ff;
      peak_in     = peak_ff;
      drop_in     = drop_ff;
      n_in        = n_ff;
      scan_idx_in = scan_idx_ff;
      scan_vld_in = scan_vld_ff;
      prev_in     = prev_ff;
      next_in     = next_ff;
      has_prev_in = has_prev_ff;
      has_next_in = has_next_ff;
      pos_in      = pos_ff;
      mv_src_in   = mv_src_ff;
      mv_dst_in   = mv_dst_ff;
      mv_left_in  = mv_left_ff;
      mv_up_in    = mv_up_ff;
      mv_pend_in  = 1'b0;
      mv_ret_in   = mv_ret_ff;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      idle        = 1'b0;
      done        = 1'b0;

      unique case (state_ff)
         PRA_IDLE: begin
            idle = 1'b1;
            if (start) begin
               cmd_in   = cmd;
               state_in = PRA_DECODE;
            end
         end
         PRA_DECODE: begin
            raddr_in    = '0;
            scan_idx_in = '0;
            scan_vld_in = (n_ff != '0);
            has_prev_in = 1'b0;
            has_next_in = 1'b0;
            state_in    = PRA_DONE;
            if (cmd_ff.command == CMD_ALLOCATE) begin
               priority if (cmd_ff.num_pages == '0) begin
                  status_in = STS_ZERO;
               end else if (count_over_cap) begin
                  status_in = STS_OVER_CAP;
               end else begin
                  state_in = PRA_TAKE_SCAN;
               end
            end else begin
               priority if (cmd_ff.address == '0 || cmd_ff.num_pages == '0) begin
                  status_in = STS_ZERO;
               end else if (cmd_ff.address < arena_base || rel_offset >= size64) begin
                  status_in = STS_OUTSIDE;
               end else if (count_over_cap) begin
                  status_in = STS_OVER_CAP;
               end else if (cmd_ff.address[PAGE_SHIFT-1:0] != '0) begin
                  status_in = STS_MISALIGNED;
               end else begin
                  status_in = STS_OK;
                  in_use_in = (in_use_ff >= cmd_ff.num_pages) ?
                              in_use_ff - cmd_ff.num_pages : '0;
                  page_in   = BASE_W'(cmd_ff.address >> PAGE_SHIFT);
                  state_in  = PRA_INS_SCAN;
               end
            end
         end
         PRA_TAKE_SCAN: begin
            rd_addr = scan_nxt[AW-1:0];
            priority if (!scan_vld_ff) begin
               state_in = PRA_BUMP_USED;
            end else if (rd_data_ff.len >= cmd_ff.num_pages) begin
               raddr_in = ADDR_W'(rd_data_ff.base) << PAGE_SHIFT;
               if (rd_data_ff.len == cmd_ff.num_pages) begin
                  n_in       = n_ff - 1'b1;
                  mv_src_in  = scan_nxt;
                  mv_left_in = n_ff - scan_nxt;
                  mv_up_in   = 1'b0;
                  mv_ret_in  = PRA_TAKE_DONE;
                  state_in   = PRA_MOVE;
               end else begin
                  wr_en        = 1'b1;
                  wr_addr      = scan_idx_ff[AW-1:0];
                  wr_data.base = rd_data_ff.base + BASE_W'(cmd_ff.num_pages);
                  wr_data.len  = rd_data_ff.len - cmd_ff.num_pages;
                  state_in     = PRA_TAKE_DONE;
               end
            end else begin
               scan_idx_in = scan_nxt;
               scan_vld_in = (scan_nxt < n_ff);
            end
         end
         PRA_BUMP_USED: begin
            used_in  = bump_ff - arena_base;
            state_in = PRA_BUMP_FIT;
         end
         PRA_BUMP_FIT: begin
            if (used_ff > size64 || bytes > size64 - used_ff) begin
               status_in = STS_NO_SPACE;
               state_in  = PRA_DONE;
            end else begin
               raddr_in = bump_ff;
               bump_in  = bump_ff + bytes;
               state_in = PRA_TAKE_DONE;
            end
         end
         PRA_TAKE_DONE: begin
            if (cmd_ff.backing_failed) begin
               status_in   = STS_BACKING_FAILED;
               page_in     = BASE_W'(raddr_ff >> PAGE_SHIFT);
               scan_idx_in = '0;
               scan_vld_in = (n_ff != '0);
               has_prev_in = 1'b0;
               has_next_in = 1'b0;
               state_in    = PRA_INS_SCAN;
            end else begin
               status_in = STS_OK;
               in_use_in = use_sum[LEN_W] ? '1 : use_sum[LEN_W-1:0];
               state_in  = PRA_DONE;
            end
         end
         PRA_INS_SCAN: begin
            rd_addr = scan_nxt[AW-1:0];
            priority if (!scan_vld_ff) begin
               pos_in   = scan_idx_ff;
               state_in = PRA_INS_DECIDE;
            end else if (rd_data_ff.base < page_ff) begin
               prev_in     = rd_data_ff;
               has_prev_in = 1'b1;
               scan_idx_in = scan_nxt;
               scan_vld_in = (scan_nxt < n_ff);
            end else begin
               next_in     = rd_data_ff;
               has_next_in = 1'b1;
               pos_in      = scan_idx_ff;
               state_in    = PRA_INS_DECIDE;
            end
         end
         PRA_INS_DECIDE: begin
            state_in = PRA_DONE;
            priority if (has_prev_ff && prev_end == {1'b0, page_ff} && !prev_len_sum[LEN_W]) begin
               prev_in.len = prev_len_sum[LEN_W-1:0];
               state_in    = PRA_INS_MERGE;
            end else if (has_next_ff && page_end == {1'b0, next_ff.base} &&
                         !next_len_sum[LEN_W]) begin
               wr_en        = 1'b1;
               wr_addr      = pos_ff[AW-1:0];
               wr_data.base = page_ff;
               wr_data.len  = next_len_sum[LEN_W-1:0];
            end else if (n_ff >= DEPTH_CNT) begin
               if (drop_ff != '1) begin
                  drop_in = drop_ff + 1'b1;
               end
            end else if (pos_ff == n_ff) begin
               wr_en        = 1'b1;
               wr_addr      = pos_ff[AW-1:0];
               wr_data.base = page_ff;
               wr_data.len  = cmd_ff.num_pages;
               n_in         = n_ff + 1'b1;
            end else begin
               mv_src_in  = n_ff - 1'b1;
               mv_left_in = n_ff - pos_ff;
               mv_up_in   = 1'b1;
               mv_ret_in  = PRA_INS_PUT;
               state_in   = PRA_MOVE;
            end
         end
         PRA_INS_MERGE: begin
            wr_en        = 1'b1;
            wr_addr      = AW'(pos_ff - 1'b1);
            wr_data.base = prev_ff.base;
            state_in     = PRA_DONE;
            if (has_next_ff && prev_end == {1'b0, next_ff.base} && !join_len_sum[LEN_W]) begin
               wr_data.len = join_len_sum[LEN_W-1:0];
               n_in        = n_ff - 1'b1;
               mv_src_in   = pos_ff + 1'b1;
               mv_left_in  = n_ff - pos_ff - 1'b1;
               mv_up_in    = 1'b0;
               mv_ret_in   = PRA_DONE;
               state_in    = PRA_MOVE;
            end else begin
               wr_data.len = prev_ff.len;
            end
         end
         PRA_INS_PUT: begin
            wr_en        = 1'b1;
            wr_addr      = pos_ff[AW-1:0];
            wr_data.base = page_ff;
            wr_data.len  = cmd_ff.num_pages;
            n_in         = n_ff + 1'b1;
            state_in     = PRA_DONE;
         end
         PRA_MOVE: begin
            wr_en   = mv_pend_ff;
            wr_addr = mv_dst_ff[AW-1:0];
            wr_data = rd_data_ff;
            rd_addr = mv_src_ff[AW-1:0];
            if (mv_left_ff != '0) begin
               mv_pend_in = 1'b1;
               mv_dst_in  = mv_up_ff ? mv_src_ff + 1'b1 : mv_src_ff - 1'b1;
               mv_src_in  = mv_up_ff ? mv_src_ff - 1'b1 : mv_src_ff + 1'b1;
               mv_left_in = mv_left_ff - 1'b1;
            end else if (!mv_pend_ff) begin
               state_in = mv_ret_ff;
            end
         end
         PRA_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               peak_in  = (in_use_ff > peak_ff) ? in_use_ff : peak_ff;
               state_in = PRA_IDLE;
            end
         end
         default: begin
            state_in = PRA_IDLE;
         end
      endcase

      if (bump_load) begin
         bump_in = bump_value;
      end
   end

   assign result.status           = status_ff;
   assign result.range_address    = (status_ff == STS_OK) ? raddr_ff : '0;
   assign result.pages_in_use     = in_use_ff;
   assign result.high_water_mark  = peak_in;
   assign result.free_range_count = free_wide[FREE_W-1:0];
   assign result.forfeited_ranges = drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= PRA_IDLE;
         bump_ff     <= '0;
         in_use_ff   <= '0;
         peak_ff     <= '0;
         drop_ff     <= '0;
         n_ff        <= '0;
         scan_vld_ff <= 1'b0;
         mv_pend_ff  <= 1'b0;
         has_prev_ff <= 1'b0;
         has_next_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         bump_ff     <= bump_in;
         in_use_ff   <= in_use_in;
         peak_ff     <= peak_in;
         drop_ff     <= drop_in;
         n_ff        <= n_in;
         scan_vld_ff <= scan_vld_in;
         mv_pend_ff  <= mv_pend_in;
         has_prev_ff <= has_prev_in;
         has_next_ff <= has_next_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      page_ff     <= page_in;
      status_ff   <= status_in;
      raddr_ff    <= raddr_in;
      used_ff     <= used_in;
      scan_idx_ff <= scan_idx_in;
      prev_ff     <= prev_in;
      next_ff     <= next_in;
      pos_ff      <= pos_in;
      mv_src_ff   <= mv_src_in;
      mv_dst_ff   <= mv_dst_in;
      mv_left_ff  <= mv_left_in;
      mv_up_ff    <= mv_up_in;
      mv_ret_ff   <= mv_ret_in;
   end

endmodule

### rtl/core/page_range_allocator_top.sv
// Top level of the page range allocator: registers, channels and the list engine.
//
//   Channel  Dir  Handshake        Word
//   req      in   valid / ready    command, num_pages, address, backing_failed
//   rsp      out  valid / ready    status, range_address, usage and list counters
//   csr      in   csr_we           csr_index, csr_wdata (arena_base, arena_size)
//
// One word is served at a time. A first-fit or address-ordered scan visits the free list
// entries and a removal or insertion moves entries, one per cycle through the single list
// memory; an allocation that fails backing runs a take and an insert back to back.
// Reset is synchronous and empties the list without touching the memory.
// A new request is taken while an earlier response still waits in the output register;
// the engine holds its finished word until that register is free.
module page_range_allocator_top import pra_pkg::*; #(
   parameter int FREE_LIST_DEPTH = PRA_FREE_LIST_DEPTH,
   parameter int PAGE_BYTES      = PRA_PAGE_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   pra_req_if.sink              req_bus,
   pra_rsp_if.source            rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);

   logic [ADDR_W-1:0] arena_base_ff, arena_base_in;
   logic [SIZE_W-1:0] arena_size_ff, arena_size_in;
   logic              rsp_valid_ff, rsp_valid_in;
   pra_result_type    rsp_data_ff, rsp_data_in;
   pra_cmd_type       cmd;
   pra_result_type    result;
   logic              idle;
   logic              done;
   logic              out_free;
   logic              bump_load;

   assign cmd.command        = req_bus.command;
   assign cmd.num_pages      = req_bus.num_pages;
   assign cmd.address        = req_bus.address;
   assign cmd.backing_failed = req_bus.backing_failed;

   assign req_bus.ready = idle;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign bump_load     = csr_we && csr_index == CSR_ARENA_BASE;

   pra_engine #(
      .FREE_LIST_DEPTH (FREE_LIST_DEPTH),
      .PAGE_BYTES      (PAGE_BYTES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (req_bus.valid),
      .cmd        (cmd),
      .out_free   (out_free),
      .arena_base (arena_base_ff),
      .arena_size (arena_size_ff),
      .bump_load  (bump_load),
      .bump_value (csr_wdata),
      .idle       (idle),
      .done       (done),
      .result     (result)
   );

   always_comb begin
      arena_base_in = arena_base_ff;
      arena_size_in = arena_size_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ARENA_BASE: arena_base_in = csr_wdata;
            CSR_ARENA_SIZE: arena_size_in = csr_wdata[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_base_ff <= '0;
         arena_size_ff <= ARENA_SIZE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         arena_base_ff <= arena_base_in;
         arena_size_ff <= arena_size_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.status           = rsp_data_ff.status;
   assign rsp_bus.range_address    = rsp_data_ff.range_address;
   assign rsp_bus.pages_in_use     = rsp_data_ff.pages_in_use;
   assign rsp_bus.high_water_mark  = rsp_data_ff.high_water_mark;
   assign rsp_bus.free_range_count = rsp_data_ff.free_range_count;
   assign rsp_bus.forfeited_ranges = rsp_data_ff.forfeited_ranges;

endmodule

### bench/page_range_allocator_top_test.sv
// Self-checking testbench of the page range allocator with a scoreboard and random traffic.
`timescale 1ns / 1ps

import pra_pkg::*;

class allocator_scoreboard;
   localparam logic [63:0] LEN_MAX = 64'hF_FFFF_FFFF;
   localparam int DEPTH = PRA_FREE_LIST_DEPTH;

   logic [63:0] arena_base;
   logic [63:0] arena_size;
   logic [63:0] bump;
   logic [51:0] base_page [DEPTH];
   logic [35:0] length_pages [DEPTH];
   int unsigned entries;
   logic [35:0] in_use;
   logic [35:0] peak;
   logic [31:0] dropped;
   pra_result_type pending [$];
   int errors;

   function new();
      arena_base = '0;
      arena_size = 64'(ARENA_SIZE_RESET);
      bump = '0;
      entries = 0;
      in_use = '0;
      peak = '0;
      dropped = '0;
      errors = 0;
   endfunction

   function void write_register(logic [CSR_IDX_W-1:0] index, logic [63:0] value);
      if (index == CSR_ARENA_BASE) begin
         arena_base = value;
         bump = value;
      end else begin
         arena_size = value & 64'h1_FFFF_FFFF_FFFF;
      end
   endfunction

   function void remove_at(int unsigned pos);
      for (int unsigned i = pos; i + 1 < entries; i++) begin
         base_page[i] = base_page[i + 1];
         length_pages[i] = length_pages[i + 1];
      end
      if (entries > 0) entries--;
   endfunction

   function void insert_range(logic [63:0] page, logic [63:0] count);
      int unsigned pos;
      int unsigned p;
      pos = 0;
      while (pos < entries && 64'(base_page[pos]) < page) pos++;
      if (pos > 0) begin
         p = pos - 1;
         if (64'(base_page[p]) + 64'(length_pages[p]) == page &&
             64'(length_pages[p]) + count <= LEN_MAX) begin
            length_pages[p] = 36'(64'(length_pages[p]) + count);
            if (pos < entries &&
                64'(base_page[p]) + 64'(length_pages[p]) == 64'(base_page[pos]) &&
                64'(length_pages[p]) + 64'(length_pages[pos]) <= LEN_MAX) begin
               length_pages[p] = length_pages[p] + length_pages[pos];
               remove_at(pos);
            end
            return;
         end
      end
      if (pos < entries && page + count == 64'(base_page[pos]) &&
          64'(length_pages[pos]) + count <= LEN_MAX) begin
         base_page[pos] = 52'(page);
         length_pages[pos] = 36'(64'(length_pages[pos]) + count);
         return;
      end
      if (entries >= DEPTH) begin
         if (dropped != 32'hFFFF_FFFF) dropped++;
         return;
      end
      for (int unsigned i = entries; i > pos; i--) begin
         base_page[i] = base_page[i - 1];
         length_pages[i] = length_pages[i - 1];
      end
      base_page[pos] = 52'(page);
      length_pages[pos] = 36'(count);
      entries++;
   endfunction

   function bit take_range(logic [63:0] count, output logic [63:0] addr);
      addr = '0;
      for (int unsigned i = 0; i < entries; i++) begin
         if (64'(length_pages[i]) >= count) begin
            addr = 64'(base_page[i]) * 64'(PRA_PAGE_BYTES);
            if (64'(length_pages[i]) == count) begin
               remove_at(i);
            end else begin
               base_page[i] = 52'(64'(base_page[i]) + count);
               length_pages[i] = 36'(64'(length_pages[i]) - count);
            end
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function status_type allocate(logic [63:0] count, logic failed, output logic [63:0] addr);
      logic [63:0] cap;
      logic [63:0] base;
      logic [63:0] used;
      logic [63:0] bytes;
      logic [63:0] total;
      cap = arena_size / PRA_PAGE_BYTES;
      addr = '0;
      if (count == 0) return STS_ZERO;
      if (count > cap) return STS_OVER_CAP;
      if (!take_range(count, base)) begin
         used = bump - arena_base;
         bytes = count * PRA_PAGE_BYTES;
         if (used > arena_size || bytes > arena_size - used) return STS_NO_SPACE;
         base = bump;
         bump = bump + bytes;
      end
      if (failed) begin
         insert_range(base / PRA_PAGE_BYTES, count);
         return STS_BACKING_FAILED;
      end
      total = 64'(in_use) + count;
      in_use = (total > LEN_MAX) ? 36'(LEN_MAX) : 36'(total);
      if (in_use > peak) peak = in_use;
      addr = base;
      return STS_OK;
   endfunction

   function status_type release_range(logic [63:0] count, logic [63:0] address);
      logic [63:0] cap;
      cap = arena_size / PRA_PAGE_BYTES;
      if (address == 0 || count == 0) return STS_ZERO;
      if (address < arena_base || address - arena_base >= arena_size) return STS_OUTSIDE;
      if (count > cap) return STS_OVER_CAP;
      if (address % PRA_PAGE_BYTES != 0) return STS_MISALIGNED;
      in_use = (64'(in_use) >= count) ? 36'(64'(in_use) - count) : '0;
      insert_range(address / PRA_PAGE_BYTES, count);
      return STS_OK;
   endfunction

   function pra_result_type note(pra_cmd_type word);
      pra_result_type res;
      logic [63:0] addr;
      addr = '0;
      if (word.command == CMD_ALLOCATE)
         res.status = allocate(64'(word.num_pages), word.backing_failed, addr);
      else
         res.status = release_range(64'(word.num_pages), word.address);
      res.range_address = addr;
      res.pages_in_use = in_use;
      res.high_water_mark = peak;
      res.free_range_count = 8'(entries);
      res.forfeited_ranges = dropped;
      pending.push_back(res);
      return res;
   endfunction

   function void check(pra_result_type got);
      pra_result_type want;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("Unexpected response word: %p", got);
         return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.range_address !== want.range_address ||
          got.pages_in_use !== want.pages_in_use ||
          got.high_water_mark !== want.high_water_mark ||
          got.free_range_count !== want.free_range_count ||
          got.forfeited_ranges !== want.forfeited_ranges) begin
         errors++;
         if (errors <= 10) $display("Mismatch: expected %p, actual %p", want, got);
      end
   endfunction
endclass

module page_range_allocator_top_test;
   typedef struct {
      logic [63:0] addr;
      logic [35:0] count;
   } held_range_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0] csr_wdata;
   bit steady;
   int quiet_cycles;
   allocator_scoreboard board;
   held_range_type held [$];

   pra_req_if req_bus ();
   pra_rsp_if rsp_bus ();

   page_range_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 23);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check('{rsp_bus.status, rsp_bus.range_address, rsp_bus.pages_in_use,
                       rsp_bus.high_water_mark, rsp_bus.free_range_count,
                       rsp_bus.forfeited_ranges});
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 40000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_word(input logic cmd, input logic [35:0] count,
                            input logic [63:0] address, input logic failed);
      pra_result_type res;
      @(negedge clock);
      while (!steady && $urandom_range(99) < 23) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.num_pages <= count;
      req_bus.address <= address;
      req_bus.backing_failed <= failed;
      do @(posedge clock); while (!req_bus.ready);
      res = board.note('{cmd, count, address, failed});
      if (cmd == CMD_ALLOCATE && res.status == STS_OK)
         held.push_back('{res.range_address, count});
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [63:0] value);
      drain();
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      board.write_register(index, value);
      held.delete();
   endtask

   task automatic run_random(input int n, input int max_count);
      int pick;
      int k;
      held_range_type r;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 35 && held.size() > 0) begin
            k = $urandom_range(held.size() - 1);
            r = held[k];
            held.delete(k);
            send_word(CMD_RELEASE, r.count, r.addr, 1'($urandom_range(1)));
         end else if (pick < 82) begin
            send_word(CMD_ALLOCATE, 36'($urandom_range(1, max_count)), {$urandom, $urandom},
                      $urandom_range(99) < 8);
         end else if (pick < 91) begin
            send_word(1'($urandom_range(1)), 36'({$urandom, $urandom}), {$urandom, $urandom},
                      1'($urandom_range(1)));
         end else begin
            send_word(CMD_RELEASE, 36'($urandom_range(0, max_count)),
                      board.arena_base + 64'($urandom_range(0, 4095)) * 4096 +
                      64'($urandom_range(0, 1) * $urandom_range(1, 4095)),
                      1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      steady = 1'b0;
      quiet_cycles = 0;
      csr_we = 1'b0;
      csr_index = CSR_ARENA_BASE;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_ALLOCATE;
      req_bus.num_pages = '0;
      req_bus.address = '0;
      req_bus.backing_failed = 1'b0;
      rsp_bus.ready = 1'b0;
      board = new();
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      send_word(CMD_ALLOCATE, 36'd0, 64'd0, 1'b0);
      send_word(CMD_ALLOCATE, '1, '1, 1'b1);
      send_word(CMD_ALLOCATE, 36'h8_0000_0000, 64'd0, 1'b0);
      send_word(CMD_ALLOCATE, 36'd4, 64'd0, 1'b0);
      send_word(CMD_ALLOCATE, 36'd1, 64'd0, 1'b1);
      send_word(CMD_ALLOCATE, 36'd1, 64'd0, 1'b0);
      send_word(CMD_RELEASE, 36'd1, 64'd0, 1'b0);
      send_word(CMD_RELEASE, 36'd0, 64'h2000, 1'b0);
      send_word(CMD_RELEASE, 36'd1, '1, 1'b1);
      send_word(CMD_RELEASE, 36'h4_0000_0000, 64'h1000, 1'b0);
      send_word(CMD_RELEASE, 36'd1, 64'h1001, 1'b0);
      send_word(CMD_RELEASE, 36'd1, 64'h1000, 1'b0);
      send_word(CMD_RELEASE, 36'd1, 64'h3000, 1'b1);
      send_word(CMD_RELEASE, 36'd1, 64'h2000, 1'b0);
      send_word(CMD_RELEASE, 36'd1, 64'h2000, 1'b0);
      send_word(CMD_RELEASE, 36'd1, 64'hFFFF_FFFF_FFFF_F000, 1'b0);
      held.delete();
      run_random(60, 16);

      write_csr(CSR_ARENA_SIZE, 64'd281474976710656);
      write_csr(CSR_ARENA_BASE, 64'h1000);
      send_word(CMD_RELEASE, '1, 64'h1000, 1'b0);
      send_word(CMD_RELEASE, 36'd2, 64'h1000 + 64'hF_FFFF_FFFF * 4096, 1'b0);
      send_word(CMD_ALLOCATE, '1, 64'd0, 1'b0);
      send_word(CMD_ALLOCATE, '1, 64'd0, 1'b0);
      send_word(CMD_ALLOCATE, 36'd3, 64'd0, 1'b1);
      run_random(80, 64);

      write_csr(CSR_ARENA_BASE, 64'h4000_0000);
      write_csr(CSR_ARENA_SIZE, 64'd64 * 4096);
      steady = 1'b1;
      run_random(100, 8);
      steady = 1'b0;
      drain();
      run_random(80, 8);

      write_csr(CSR_ARENA_BASE, 64'h4000_0123);
      write_csr(CSR_ARENA_SIZE, 64'd4096);
      run_random(50, 2);

      write_csr(CSR_ARENA_BASE, 64'hFFFF_FFFF_FFFF_F000);
      write_csr(CSR_ARENA_SIZE, 64'd256 * 4096);
      run_random(80, 8);

      write_csr(CSR_ARENA_BASE, 64'h10_0000);
      write_csr(CSR_ARENA_SIZE, 64'd1024 * 4096);
      for (int i = 0; i < 300; i++) send_word(CMD_ALLOCATE, 36'd1, 64'd0, 1'b0);
      for (int i = 1; i < 300; i += 2)
         send_word(CMD_RELEASE, 36'd1, 64'h10_0000 + 64'(i) * 4096, 1'b0);
      send_word(CMD_ALLOCATE, 36'd1, 64'd0, 1'b1);
      send_word(CMD_RELEASE, 36'd1, 64'h10_0000 + 64'd299 * 4096, 1'b0);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_ARENA_SIZE;
      csr_wdata <= 64'd4096;
      @(negedge clock);
      csr_we <= 1'b0;
      board.write_register(CSR_ARENA_SIZE, 64'd4096);
      run_random(40, 2);

      drain();
      repeat (600) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
